FILE: rtl/hydrostatic_face_reconstruction_macros.svh
// Assertion macros shared by the face reconstruction RTL.
`ifndef HYDROSTATIC_FACE_RECONSTRUCTION_MACROS_SVH
`define HYDROSTATIC_FACE_RECONSTRUCTION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HFR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/hfr_pkg.sv
// Shared constants, types and saturation helpers for the face reconstruction block.
`default_nettype none
package hfr_pkg;

	localparam int DIV_BITS   = 4;
	localparam int QW         = 48;
	localparam int DIV_STAGES = QW / DIV_BITS;

	typedef struct packed {
		logic neg;
		logic dry;
	} lane_ctl_t;

	function automatic logic signed [31:0] sat_wide(logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat_q(logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > 48'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -48'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/hfr_vel_div.sv
// Velocity pipe: restoring division of scaled momentum by depth, then sign, saturation, dry zeroing.
`default_nettype none
module hfr_vel_div (
	input  logic                         clk,
	input  logic [hfr_pkg::DIV_STAGES:0] en,
	input  hfr_pkg::lane_ctl_t           ctl,
	input  logic [hfr_pkg::QW-1:0]       dividend,
	input  logic [30:0]                  divisor,
	output logic signed [31:0]           vel
);
	import hfr_pkg::*;

	function automatic logic [QW+30:0] div_step(logic [30:0] r_in, logic [QW-1:0] q_in,
			logic [30:0] d);
		logic [31:0]   t;
		logic [30:0]   r;
		logic [QW-1:0] q;
		r = r_in;
		q = q_in;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r, q[QW-1]};
			q = {q[QW-2:0], 1'b0};
			if (t >= {1'b0, d}) begin
				t    = t - {1'b0, d};
				q[0] = 1'b1;
			end
			r = t[30:0];
		end
		return {r, q};
	endfunction

	logic [30:0]   rem_s [DIV_STAGES];
	logic [QW-1:0] quo_s [DIV_STAGES];
	logic [30:0]   dsr_s [DIV_STAGES];
	lane_ctl_t     ctl_s [DIV_STAGES];
	logic signed [31:0] vel_sat_s;

	genvar g;
	generate
		for (g = 0; g < DIV_STAGES; g++) begin : g_div
			logic [QW+30:0] nxt;
			if (g == 0) begin : g_first
				assign nxt = div_step(31'd0, dividend, divisor);
				always_ff @(posedge clk) begin
					if (en[g]) begin
						dsr_s[g] <= divisor;
						ctl_s[g] <= ctl;
					end
				end
			end else begin : g_rest
				assign nxt = div_step(rem_s[g-1], quo_s[g-1], dsr_s[g-1]);
				always_ff @(posedge clk) begin
					if (en[g]) begin
						dsr_s[g] <= dsr_s[g-1];
						ctl_s[g] <= ctl_s[g-1];
					end
				end
			end
			always_ff @(posedge clk) begin
				if (en[g]) begin
					rem_s[g] <= nxt[QW+30:QW];
					quo_s[g] <= nxt[QW-1:0];
				end
			end
		end
	endgenerate

	// The quotient is a magnitude; a negative result may reach exactly -2^31.
	logic [QW-1:0] qm;
	logic signed [31:0] vel_nxt;
	assign qm = quo_s[DIV_STAGES-1];
	always_comb begin
		if (ctl_s[DIV_STAGES-1].dry) begin
			vel_nxt = 32'sd0;
		end else if (ctl_s[DIV_STAGES-1].neg) begin
			if (qm[QW-1:32] != '0 || (qm[31] && qm[30:0] != '0)) begin
				vel_nxt = 32'sh80000000;
			end else begin
				vel_nxt = -$signed(qm[31:0]);
			end
		end else if (qm[QW-1:31] != '0) begin
			vel_nxt = 32'sh7fffffff;
		end else begin
			vel_nxt = $signed(qm[31:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[DIV_STAGES]) begin
			vel_sat_s <= vel_nxt;
		end
	end

	assign vel = vel_sat_s;

endmodule
`default_nettype wire

FILE: rtl/hydrostatic_face_reconstruction.sv
// Top level of the hydrostatic face reconstruction pipeline.
// Usage:
//   Input channel: in_valid with a face node word; the block raises in_stall when it
//   cannot take it. A word is taken on a clock edge with in_valid high and in_stall low.
//   Output channel: out_valid with the reconstructed word; the receiver holds out_stall
//   high to keep the word in place. It is taken when out_valid is high and out_stall low.
//   Config channel: cfg_valid/cfg_ready write depth_threshold; cfg_ready is always high.
//   Write it only while no word is in flight.
//   One word is accepted per cycle while in_stall is low.
//   Twelve division stages of four quotient bits each set the depth of the pipeline,
//   followed by a saturation stage, a multiply stage and an output stage.
//   A stalled receiver holds the output stage; empty stages behind it keep filling,
//   so in_stall rises only when every stage holds a word.
//   Reset empties the pipeline and sets the threshold to 66 (Q16.16).
`default_nettype none
module hydrostatic_face_reconstruction (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] depth_inner,
	input  logic signed [31:0] momx_inner,
	input  logic signed [31:0] momy_inner,
	input  logic signed [31:0] bed_inner,
	input  logic signed [31:0] depth_outer,
	input  logic signed [31:0] momx_outer,
	input  logic signed [31:0] momy_outer,
	input  logic signed [31:0] bed_outer,
	input  logic               last_node,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] new_depth_inner,
	output logic signed [31:0] new_momx_inner,
	output logic signed [31:0] new_momy_inner,
	output logic signed [31:0] new_depth_outer,
	output logic signed [31:0] new_momx_outer,
	output logic signed [31:0] new_momy_outer,
	output logic signed [31:0] shared_bed,
	output logic               last_out
);
	import hfr_pkg::*;

	localparam int NS     = DIV_STAGES + 4;
	localparam int ST_SAT = DIV_STAGES + 2;
	localparam int ST_MUL = DIV_STAGES + 3;

	logic [30:0] thr_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 31'd66;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// Stage enables: a stage loads when it is empty or the stage after it moves.
	logic [NS:1] valid_s;
	logic [NS:1] en;
	always_comb begin
		en[NS] = !valid_s[NS] || !out_stall;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !valid_s[k] || en[k+1];
		end
	end
	assign in_stall = !en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (en[1]) begin
				valid_s[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	// Stage 1: divider operands per lane and the raw depth/bed values.
	logic signed [31:0] mom_in [4];
	logic signed [31:0] dep_in [4];
	assign mom_in[0] = momx_inner;
	assign mom_in[1] = momy_inner;
	assign mom_in[2] = momx_outer;
	assign mom_in[3] = momy_outer;
	assign dep_in[0] = depth_inner;
	assign dep_in[1] = depth_inner;
	assign dep_in[2] = depth_outer;
	assign dep_in[3] = depth_outer;

	lane_ctl_t     ctl_s1 [4];
	logic [QW-1:0] dvd_s1 [4];
	logic [30:0]   dsr_s1 [4];
	logic signed [31:0] hi_s1, zi_s1, ho_s1, zo_s1;
	logic last_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int l = 0; l < 4; l++) begin
				ctl_s1[l].neg <= mom_in[l][31];
				// A depth not above the threshold (negative depths included) is dry.
				ctl_s1[l].dry <= !(dep_in[l] > $signed({1'b0, thr_q}));
				dvd_s1[l]     <= {(mom_in[l][31] ? 32'd0 - mom_in[l] : mom_in[l]), 16'd0};
				dsr_s1[l]     <= dep_in[l][30:0];
			end
			hi_s1   <= depth_inner;
			zi_s1   <= bed_inner;
			ho_s1   <= depth_outer;
			zo_s1   <= bed_outer;
			last_s1 <= last_node;
		end
	end

	logic signed [31:0] vel_s14 [4];
	genvar gl;
	generate
		for (gl = 0; gl < 4; gl++) begin : g_lane
			hfr_vel_div u_div (
				.clk      (clk),
				.en       (en[ST_SAT:2]),
				.ctl      (ctl_s1[gl]),
				.dividend (dvd_s1[gl]),
				.divisor  (dsr_s1[gl]),
				.vel      (vel_s14[gl])
			);
		end
	endgenerate

	// Depth path, computed exactly at 36 bits, then saturated.
	logic signed [35:0] eta_i, eta_o, zmax, zs, ndi_w, a_w, b_w, ndo_w;
	always_comb begin
		eta_i = 36'(hi_s1) + 36'(zi_s1);
		eta_o = 36'(ho_s1) + 36'(zo_s1);
		zmax  = (zi_s1 > zo_s1) ? 36'(zi_s1) : 36'(zo_s1);
		zs    = (eta_i < zmax) ? eta_i : zmax;
		ndi_w = eta_i - zs;
		a_w   = eta_o - zs;
		if (a_w < 0) begin
			a_w = '0;
		end
		b_w = 36'(zo_s1) - zs;
		if (b_w < 0) begin
			b_w = '0;
		end
		ndo_w = a_w - b_w;
	end

	logic signed [31:0] ndi_d [2:ST_SAT];
	logic signed [31:0] ndo_d [2:ST_SAT];
	logic signed [31:0] zs_d  [2:ST_SAT];
	logic               last_d [2:ST_SAT];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ndi_d[2]  <= sat_wide(ndi_w);
			ndo_d[2]  <= sat_wide(ndo_w);
			zs_d[2]   <= sat_wide(zs);
			last_d[2] <= last_s1;
		end
		for (int k = 3; k <= ST_SAT; k++) begin
			if (en[k]) begin
				ndi_d[k]  <= ndi_d[k-1];
				ndo_d[k]  <= ndo_d[k-1];
				zs_d[k]   <= zs_d[k-1];
				last_d[k] <= last_d[k-1];
			end
		end
	end

	// Multiply stage: new depth times velocity per lane.
	logic signed [63:0] prod_s15 [4];
	logic signed [31:0] ndi_s15, ndo_s15, zs_s15;
	logic last_s15;
	always_ff @(posedge clk) begin
		if (en[ST_MUL]) begin
			prod_s15[0] <= ndi_d[ST_SAT] * vel_s14[0];
			prod_s15[1] <= ndi_d[ST_SAT] * vel_s14[1];
			prod_s15[2] <= ndo_d[ST_SAT] * vel_s14[2];
			prod_s15[3] <= ndo_d[ST_SAT] * vel_s14[3];
			ndi_s15  <= ndi_d[ST_SAT];
			ndo_s15  <= ndo_d[ST_SAT];
			zs_s15   <= zs_d[ST_SAT];
			last_s15 <= last_d[ST_SAT];
		end
	end

	// Output stage: arithmetic shift by 16 floors, then saturate.
	logic signed [31:0] mom_s16 [4];
	logic signed [31:0] ndi_s16, ndo_s16, zs_s16;
	logic last_s16;
	always_ff @(posedge clk) begin
		if (en[NS]) begin
			for (int l = 0; l < 4; l++) begin
				mom_s16[l] <= sat_q(prod_s15[l][63:16]);
			end
			ndi_s16  <= ndi_s15;
			ndo_s16  <= ndo_s15;
			zs_s16   <= zs_s15;
			last_s16 <= last_s15;
		end
	end

	assign out_valid       = valid_s[NS];
	assign new_depth_inner = ndi_s16;
	assign new_momx_inner  = mom_s16[0];
	assign new_momy_inner  = mom_s16[1];
	assign new_depth_outer = ndo_s16;
	assign new_momx_outer  = mom_s16[2];
	assign new_momy_outer  = mom_s16[3];
	assign shared_bed      = zs_s16;
	assign last_out        = last_s16;

`include "hydrostatic_face_reconstruction_macros.svh"

	`HFR_ASSERT_NOW(a_stall_only_when_blocked, in_stall, out_valid && out_stall && (&valid_s), "in_stall without a full, blocked pipeline")
	`HFR_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, valid_s[1], "accepted word did not enter stage one")
	`HFR_ASSERT_NOW(a_inner_depth_nonneg, out_valid, !new_depth_inner[31], "inner depth came out negative")

endmodule
`default_nettype wire

FILE: sim/hydrostatic_face_reconstruction_test.sv
// Self-checking testbench for the hydrostatic face reconstruction pipeline.
`default_nettype none
module hydrostatic_face_reconstruction_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [31:0] depth_in;
		logic signed [31:0] momx_in;
		logic signed [31:0] momy_in;
		logic signed [31:0] bed_in;
		logic signed [31:0] depth_out;
		logic signed [31:0] momx_out;
		logic signed [31:0] momy_out;
		logic signed [31:0] bed_out;
		logic last;
	} face_node_t;

	typedef struct packed {
		logic signed [31:0] nd_in;
		logic signed [31:0] mx_in;
		logic signed [31:0] my_in;
		logic signed [31:0] nd_out;
		logic signed [31:0] mx_out;
		logic signed [31:0] my_out;
		logic signed [31:0] zstar;
		logic last;
	} face_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [30:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	face_node_t node = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	face_result_t got;

	logic [30:0] dry_limit = 31'd66;
	face_result_t reconstructed_q[$];
	int mismatches = 0;
	int cycles = 0;
	int in_idle_pct = 32;
	int out_idle_pct = 32;

	hydrostatic_face_reconstruction dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.depth_inner(node.depth_in), .momx_inner(node.momx_in),
		.momy_inner(node.momy_in), .bed_inner(node.bed_in),
		.depth_outer(node.depth_out), .momx_outer(node.momx_out),
		.momy_outer(node.momy_out), .bed_outer(node.bed_out),
		.last_node(node.last),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_depth_inner(got.nd_in), .new_momx_inner(got.mx_in),
		.new_momy_inner(got.my_in), .new_depth_outer(got.nd_out),
		.new_momx_outer(got.mx_out), .new_momy_outer(got.my_out),
		.shared_bed(got.zstar), .last_out(got.last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint speed(longint h, longint mom);
		if (h <= longint'(dry_limit) || h <= 0) return 0;
		return clamp32((mom * 65536) / h);
	endfunction

	// Floor shift of the depth-velocity product.
	function automatic longint rebuilt_mom(longint h, longint u);
		longint p, q;
		p = h * u;
		q = p / 65536;
		if (p % 65536 != 0 && p < 0) q -= 1;
		return clamp32(q);
	endfunction

	function automatic face_result_t reconstruct(face_node_t n);
		face_result_t r;
		longint hi, zi, ho, zo, eta_i, eta_o, zs, a, b, ndi, ndo;
		hi = n.depth_in; zi = n.bed_in; ho = n.depth_out; zo = n.bed_out;
		eta_i = hi + zi;
		eta_o = ho + zo;
		zs = (zi > zo) ? zi : zo;
		if (eta_i < zs) zs = eta_i;
		ndi = clamp32(eta_i - zs);
		a = eta_o - zs;
		if (a < 0) a = 0;
		b = zo - zs;
		if (b < 0) b = 0;
		ndo = clamp32(a - b);
		r.nd_in = ndi[31:0];
		r.mx_in = 32'(rebuilt_mom(ndi, speed(hi, n.momx_in)));
		r.my_in = 32'(rebuilt_mom(ndi, speed(hi, n.momy_in)));
		r.nd_out = ndo[31:0];
		r.mx_out = 32'(rebuilt_mom(ndo, speed(ho, n.momx_out)));
		r.my_out = 32'(rebuilt_mom(ndo, speed(ho, n.momy_out)));
		r.zstar = 32'(clamp32(zs));
		r.last = n.last;
		return r;
	endfunction

	// Input handshake monitor: predict on every accepted word and track config writes.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) reconstructed_q.push_back(reconstruct(node));
		if (arst_n && cfg_valid && cfg_ready) dry_limit <= cfg_data;
	end

	always @(posedge clk) begin
		face_result_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[hydrostatic_face_reconstruction] ERROR");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (reconstructed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %h", got);
			end else begin
				want = reconstructed_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h", want, got);
				end
			end
		end
		out_stall <= ($urandom_range(99) < out_idle_pct);
	end

	function automatic logic [31:0] rand_field();
		case ($urandom_range(7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'(int'($urandom_range(200)) - 100);
			3, 4: return 32'(int'($urandom_range(32'h00100000)) - 32'sh00080000);
			default: return $urandom;
		endcase
	endfunction

	// Valid stays high between back-to-back words; this task drops it only in idle cycles.
	task automatic send_node(face_node_t n);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		node <= n;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic write_limit(logic [30:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (reconstructed_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic face_node_t make_node(logic [31:0] h, logic [31:0] z,
			logic [31:0] ho, logic [31:0] zo);
		face_node_t n;
		n = {h, rand_field(), rand_field(), z, ho, rand_field(), rand_field(), zo,
			1'($urandom)};
		return n;
	endfunction

	task automatic test_directed();
		send_node('0);
		send_node('1);
		send_node({{8{32'h7fffffff}}, 1'b1});
		send_node({{8{32'h80000000}}, 1'b1});
		send_node(make_node(32'd66, 32'd0, 32'd67, 32'd0));
		send_node(make_node(32'd67, 32'd0, 32'd66, 32'd0));
		send_node(make_node(32'hffff0000, 32'd0, 32'h00010000, 32'h00050000));
		send_node(make_node(32'h00020000, 32'h00030000, 32'h00010000, 32'h00050000));
		send_node({32'd1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'd1,
			32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0});
		send_node({32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b1});
		send_node(make_node(32'h00000100, 32'h80000000, 32'h00000100, 32'h7fffffff));
		send_node(make_node(32'h00010000, 32'd0, 32'h00010000, 32'h00008000));
	endtask

	task automatic test_random(int count);
		face_node_t n;
		for (int i = 0; i < count; i++) begin
			n = {rand_field(), rand_field(), rand_field(), rand_field(), rand_field(),
				rand_field(), rand_field(), rand_field(), 1'($urandom)};
			if ($urandom_range(3) != 0) begin
				// Physically plausible node: small non-negative depths, nearby beds.
				n.depth_in = $urandom_range(32'h00040000);
				n.depth_out = $urandom_range(32'h00040000);
				n.bed_in = 32'(int'($urandom_range(32'h00040000)) - 32'sh00020000);
				n.bed_out = 32'(int'($urandom_range(32'h00040000)) - 32'sh00020000);
			end
			send_node(n);
		end
	endtask

	task automatic test_thresholds();
		write_limit(31'd0);
		test_random(250);
		write_limit(31'h7fffffff);
		test_directed();
		test_random(150);
		write_limit(31'h00010000);
		test_random(250);
		write_limit(31'd66);
	endtask

	task automatic test_no_idle();
		in_idle_pct = 0;
		out_idle_pct = 0;
		test_random(250);
		in_idle_pct = 32;
		out_idle_pct = 32;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(250);
		test_thresholds();
		test_no_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (reconstructed_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatches == 0 && reconstructed_q.size() == 0) begin
			$display("[hydrostatic_face_reconstruction] OK");
		end else begin
			$display("[hydrostatic_face_reconstruction] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: hydrostatic_face_reconstruction.f
+incdir+rtl
rtl/hfr_pkg.sv
rtl/hfr_vel_div.sv
rtl/hydrostatic_face_reconstruction.sv
sim/hydrostatic_face_reconstruction_test.sv
